/* design/heq_pkg.sv */
// Shared types and constants for the gray-level histogram equalizer.
`timescale 1ns / 1ps
`default_nettype none

package heq_pkg;

  localparam int MAX_PIXELS = 1048576;
  localparam int CNT_W      = $clog2(MAX_PIXELS + 1);
  localparam int PIX_W      = 8;
  localparam int BINS       = 1 << PIX_W;
  localparam int QUO_W      = PIX_W;
  localparam int QCNT_W     = $clog2(QUO_W);
  localparam int PROD_W     = CNT_W + QUO_W - 1;

  typedef struct packed {
    logic             hist_acc;
    logic             map_acc;
    logic             clr_we;
    logic             bld_rd;
    logic             bld_acc;
    logic             div_start;
    logic             map_we;
    logic             bld_done;
    logic [PIX_W-1:0] idx;
  } heq_cmd_t;

  typedef struct packed {
    logic div_done;
  } heq_stat_t;

endpackage

`default_nettype wire

/* design/heq_div.sv */
// Restoring divider producing one quotient bit per cycle for the map table entries.
`timescale 1ns / 1ps
`default_nettype none

module heq_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [heq_pkg::PROD_W-1:0]    dividend,
  input  wire logic [heq_pkg::CNT_W-1:0]     divisor,
  output logic [heq_pkg::QUO_W-1:0]          quotient,
  output logic                               done
);

  logic [heq_pkg::PROD_W-1:0] rem_r, rem_nxt;
  logic [heq_pkg::PROD_W-1:0] den_r, den_nxt;
  logic [heq_pkg::QUO_W-1:0]  quo_r, quo_nxt;
  logic [heq_pkg::QCNT_W-1:0] cnt_r, cnt_nxt;
  logic                       run_r, run_nxt;
  logic                       done_r, done_nxt;

  always_comb begin
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt = dividend;
      den_nxt = {divisor, {(heq_pkg::QUO_W-1){1'b0}}};
      quo_nxt = '0;
      cnt_nxt = heq_pkg::QCNT_W'(heq_pkg::QUO_W - 1);
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (rem_r >= den_r) begin
        rem_nxt = rem_r - den_r;
        quo_nxt = {quo_r[heq_pkg::QUO_W-2:0], 1'b1};
      end else begin
        quo_nxt = {quo_r[heq_pkg::QUO_W-2:0], 1'b0};
      end
      den_nxt = den_r >> 1;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

`default_nettype wire

/* design/heq_datapath.sv */
// Histogram and map memories, pixel counter, running sum and the divider.
`timescale 1ns / 1ps
`default_nettype none

module heq_datapath (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire heq_pkg::heq_cmd_t           cmd,
  input  wire logic [heq_pkg::PIX_W-1:0]   in_pixel,
  output heq_pkg::heq_stat_t               stat,
  output logic                             out_valid,
  output logic [heq_pkg::PIX_W-1:0]        out_mapped_pixel
);

  logic [heq_pkg::CNT_W-1:0] hist_mem [heq_pkg::BINS];
  logic [heq_pkg::PIX_W-1:0] map_mem  [heq_pkg::BINS];

  logic [heq_pkg::CNT_W-1:0] hist_rd_r;
  logic [heq_pkg::PIX_W-1:0] map_rd_r;
  logic                      out_valid_r;

  logic [heq_pkg::CNT_W-1:0] total_r, sum_r;
  logic                      p1v_r, wv_r;
  logic [heq_pkg::PIX_W-1:0] p1_r, wa_r;
  logic [heq_pkg::CNT_W-1:0] wd_r;

  logic                      room;
  logic                      hist_re, hist_we;
  logic [heq_pkg::PIX_W-1:0] hist_ra, hist_wa;
  logic [heq_pkg::CNT_W-1:0] hist_wd, bin_old;
  logic [heq_pkg::CNT_W+heq_pkg::PIX_W-1:0] sum_x256;
  logic [heq_pkg::PROD_W-1:0] dividend;
  logic [heq_pkg::QUO_W-1:0] quotient;
  logic                      div_done;

  assign room = total_r < heq_pkg::CNT_W'(heq_pkg::MAX_PIXELS);

  // The previous count word writes the same edge this one reads, so forward it.
  assign bin_old = (wv_r && wa_r == p1_r) ? wd_r : hist_rd_r;

  always_comb begin
    hist_re = cmd.hist_acc || cmd.bld_rd;
    hist_ra = cmd.bld_rd ? cmd.idx : in_pixel;
    hist_we = p1v_r || cmd.clr_we || cmd.bld_rd;
    hist_wa = p1v_r ? p1_r : cmd.idx;
    hist_wd = p1v_r ? bin_old + 1'b1 : '0;
  end

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[hist_wa] <= hist_wd;
    end
    if (hist_re) begin
      hist_rd_r <= hist_mem[hist_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.map_we) begin
      map_mem[cmd.idx] <= (total_r == '0) ? '0 : quotient;
    end
    if (cmd.map_acc) begin
      map_rd_r <= map_mem[in_pixel];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= '0;
      sum_r       <= '0;
      p1v_r       <= 1'b0;
      wv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.map_acc;
      p1v_r       <= cmd.hist_acc && room;
      wv_r        <= p1v_r;
      if (cmd.bld_done) begin
        total_r <= '0;
        sum_r   <= '0;
      end else begin
        if (cmd.hist_acc && room) begin
          total_r <= total_r + 1'b1;
        end
        if (cmd.bld_acc) begin
          sum_r <= sum_r + hist_rd_r;
        end
      end
    end
    p1_r <= in_pixel;
    wa_r <= p1_r;
    wd_r <= hist_wd;
  end

  assign sum_x256 = {sum_r, 8'b0} - {8'b0, sum_r};
  assign dividend = sum_x256[heq_pkg::PROD_W-1:0];

  heq_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (total_r),
    .quotient (quotient),
    .done     (div_done)
  );

  assign stat.div_done    = div_done;
  assign out_valid        = out_valid_r;
  assign out_mapped_pixel = map_rd_r;

endmodule

`default_nettype wire

/* design/heq_ctrl.sv */
// Controller that sequences the reset clear, counting, table build and mapping.
`timescale 1ns / 1ps
`default_nettype none

module heq_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic                in_kind,
  input  wire logic                in_last,
  input  wire heq_pkg::heq_stat_t  stat,
  output logic                     busy,
  output heq_pkg::heq_cmd_t        cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DRAIN,
    S_RD,
    S_ACC,
    S_START,
    S_DIV
  } state_t;

  state_t                    state_r, state_nxt;
  logic [heq_pkg::PIX_W-1:0] idx_r, idx_nxt;
  logic                      accept;

  assign busy   = state_r != S_IDLE;
  assign accept = start && !busy;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    cmd           = '0;
    cmd.idx       = idx_r;
    cmd.hist_acc  = accept && !in_kind;
    cmd.map_acc   = accept && in_kind;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_we = 1'b1;
        idx_nxt    = idx_r + 1'b1;
        if (idx_r == '1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept && !in_kind && in_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        idx_nxt   = '0;
        state_nxt = S_RD;
      end
      S_RD: begin
        cmd.bld_rd = 1'b1;
        state_nxt  = S_ACC;
      end
      S_ACC: begin
        cmd.bld_acc = 1'b1;
        state_nxt   = S_START;
      end
      S_START: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (stat.div_done) begin
          cmd.map_we = 1'b1;
          idx_nxt    = idx_r + 1'b1;
          if (idx_r == '1) begin
            cmd.bld_done = 1'b1;
            state_nxt    = S_IDLE;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

`default_nettype wire

/* design/histogram_equalize_gray.sv */
// Top level of the two-pass 8-bit gray-level histogram equalizer.
//
// A word is accepted at a rising edge where start is high and busy is low.
// A count word (in_kind = 0) adds in_pixel to the 256-bin histogram; pixels past
// the pixel limit are dropped, but in_last still ends the pass. A map word
// (in_kind = 1) returns the equalized level on out_mapped_pixel with out_valid
// high for exactly one cycle, the cycle after acceptance; in_last is ignored.
// Count and map words are accepted one per cycle while busy is low; counting runs
// as a read, increment and write pipeline on the histogram memory.
// After a count word with in_last set, busy stays high while the map table is
// built: a drain step, then for each of the 256 gray levels a histogram read,
// a running-sum add, a divider start and the divide, one quotient bit a cycle.
// The build also clears the histogram and pixel count for the next pass.
// After reset, busy is high while the 256 histogram bins are cleared.
// The receiver cannot stall; every result must be taken when it is shown.
// Map words must follow at least one completed build.
`timescale 1ns / 1ps
`default_nettype none

module histogram_equalize_gray (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic                       in_kind,
  input  wire logic [heq_pkg::PIX_W-1:0]  in_pixel,
  input  wire logic                       in_last,
  output logic                            out_valid,
  output logic [heq_pkg::PIX_W-1:0]       out_mapped_pixel
);

  heq_pkg::heq_cmd_t  cmd;
  heq_pkg::heq_stat_t stat;

  heq_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_kind (in_kind),
    .in_last (in_last),
    .stat    (stat),
    .busy    (busy),
    .cmd     (cmd)
  );

  heq_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_pixel         (in_pixel),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_mapped_pixel (out_mapped_pixel)
  );

endmodule

`default_nettype wire

/* test/histogram_equalize_gray_tb.sv */
// Self-checking testbench for the two-pass gray-level histogram equalizer.
`timescale 1ns / 1ps

module histogram_equalize_gray_tb;

  typedef enum bit {WORD_COUNT = 1'b0, WORD_MAP = 1'b1} word_kind_t;

  typedef struct {
    word_kind_t                kind;
    logic [heq_pkg::PIX_W-1:0] pixel;
    logic                      last;
    int                        gap;
  } pixel_word_t;

  localparam int RANDOM_WORDS   = 750;
  localparam int WATCHDOG_LIMIT = 20000;

  logic                      clk;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  logic                      in_kind;
  logic [heq_pkg::PIX_W-1:0] in_pixel;
  logic                      in_last;
  logic                      out_valid;
  logic [heq_pkg::PIX_W-1:0] out_mapped_pixel;

  pixel_word_t               pending_words[$];
  logic [heq_pkg::PIX_W-1:0] expected_levels[$];

  int unsigned               hist_bins[heq_pkg::BINS] = '{default: 0};
  int unsigned               counted_pixels = 0;
  logic [heq_pkg::PIX_W-1:0] level_map[heq_pkg::BINS] = '{default: '0};

  int  planned_words;
  int  accepted_words;
  int  count_words;
  int  map_words;
  int  tables_built;
  int  levels_checked;
  int  mismatches;
  int  idle_cycles;
  int  wait_left;
  bit  took;

  histogram_equalize_gray dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_kind          (in_kind),
    .in_pixel         (in_pixel),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_mapped_pixel (out_mapped_pixel)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("ERROR at %0t: %s", $realtime, what);
  endtask

  function automatic void rebuild_levels();
    longint unsigned cum;
    longint unsigned q;
    cum = 0;
    for (int g = 0; g < heq_pkg::BINS; g++) begin
      cum += hist_bins[g];
      if (counted_pixels == 0) begin
        level_map[g] = '0;
      end else begin
        q = (64'd255 * cum) / counted_pixels;
        if (q > 255) q = 255;
        level_map[g] = q[heq_pkg::PIX_W-1:0];
      end
    end
    for (int g = 0; g < heq_pkg::BINS; g++) hist_bins[g] = 0;
    counted_pixels = 0;
    tables_built++;
  endfunction

  task automatic absorb_word(input word_kind_t kind,
                             input logic [heq_pkg::PIX_W-1:0] pixel, input logic last);
    if (kind == WORD_COUNT) begin
      count_words++;
      if (counted_pixels < heq_pkg::MAX_PIXELS) begin
        hist_bins[pixel]++;
        counted_pixels++;
      end
      if (last) rebuild_levels();
    end else begin
      map_words++;
      expected_levels.push_back(level_map[pixel]);
    end
  endtask

  // Sample both sides at the rising edge; outputs are compared before the
  // word accepted at this edge is folded into the predicted state.
  always @(posedge clk) begin
    bit acc;
    logic [heq_pkg::PIX_W-1:0] want;
    acc = (rst_n === 1'b1) && (start === 1'b1) && (busy === 1'b0);
    took <= acc;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (expected_levels.size() == 0) begin
        report_mismatch($sformatf("unexpected result %0d", out_mapped_pixel));
      end else begin
        want = expected_levels.pop_front();
        levels_checked++;
        if (out_mapped_pixel !== want) begin
          report_mismatch($sformatf("mapped_pixel %0d, expected %0d", out_mapped_pixel,
                                    want));
        end
      end
    end
    if (acc) begin
      accepted_words++;
      absorb_word(word_kind_t'(in_kind), in_pixel, in_last);
    end
  end

  always @(posedge clk) begin
    if (rst_n !== 1'b1) begin
      idle_cycles <= 0;
    end else begin
      if ((start === 1'b1 && busy === 1'b0) || out_valid === 1'b1) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("Watchdog expired after %0d idle cycles.", WATCHDOG_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Inputs change on the falling edge; a word is held until it is taken.
  always @(negedge clk) begin
    pixel_word_t w;
    if (rst_n !== 1'b1) begin
      start     <= 1'b0;
      in_kind   <= 1'b0;
      in_pixel  <= '0;
      in_last   <= 1'b0;
      wait_left <= 0;
    end else if (start && !took) begin
    end else if (wait_left > 0) begin
      start     <= 1'b0;
      wait_left <= wait_left - 1;
    end else if (pending_words.size() > 0) begin
      w = pending_words.pop_front();
      start    <= 1'b1;
      in_kind  <= w.kind;
      in_pixel <= w.pixel;
      in_last  <= w.last;
      wait_left <= (pending_words.size() > 0) ? pending_words[0].gap : 0;
    end else begin
      start <= 1'b0;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic push_word(input word_kind_t kind, input int pixel, input bit last,
                           input int gap);
    pixel_word_t w;
    w.kind  = kind;
    w.pixel = pixel[heq_pkg::PIX_W-1:0];
    w.last  = last;
    w.gap   = gap;
    pending_words.push_back(w);
    planned_words++;
  endtask

  initial begin
    int n;
    int lo;
    int hi;
    int px;
    rst_n = 1'b0;

    // A first count pass with the extreme levels, then maps across it.
    push_word(WORD_COUNT, 0, 1'b0, 0);
    push_word(WORD_COUNT, 255, 1'b0, 0);
    push_word(WORD_COUNT, 128, 1'b0, 1);
    push_word(WORD_COUNT, 0, 1'b1, 0);
    push_word(WORD_MAP, 0, 1'b0, 0);
    push_word(WORD_MAP, 127, 1'b0, 0);
    push_word(WORD_MAP, 128, 1'b1, 2);
    push_word(WORD_MAP, 255, 1'b0, 0);
    push_word(WORD_MAP, 85, 1'b1, 0);
    // A pass of a single pixel gives a step from zero to full scale.
    push_word(WORD_COUNT, 37, 1'b1, 0);
    push_word(WORD_MAP, 36, 1'b0, 0);
    push_word(WORD_MAP, 37, 1'b0, 0);
    push_word(WORD_MAP, 0, 1'b0, 0);
    push_word(WORD_MAP, 255, 1'b1, 0);
    // Maps interleaved with counting still use the previous table.
    push_word(WORD_COUNT, 10, 1'b0, 0);
    push_word(WORD_MAP, 10, 1'b0, 0);
    push_word(WORD_MAP, 170, 1'b0, 0);
    push_word(WORD_COUNT, 200, 1'b0, 0);
    push_word(WORD_COUNT, 200, 1'b1, 0);
    push_word(WORD_MAP, 10, 1'b0, 0);
    push_word(WORD_MAP, 199, 1'b0, 0);
    push_word(WORD_MAP, 200, 1'b0, 0);

    while (planned_words < RANDOM_WORDS) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 40);
      if (n > RANDOM_WORDS - planned_words) n = RANDOM_WORDS - planned_words;
      if ($urandom_range(0, 1) == 0) begin
        lo = 0;
        hi = 255;
      end else begin
        lo = $urandom_range(0, 255);
        hi = $urandom_range(lo, (lo + 40 > 255) ? 255 : lo + 40);
      end
      for (int i = 0; i < n; i++) begin
        px = ($urandom_range(0, 19) == 0) ? (($urandom_range(0, 1) == 0) ? 0 : 255)
                                          : $urandom_range(lo, hi);
        push_word(WORD_COUNT, px, i == n - 1, pick_gap());
        if ($urandom_range(0, 3) == 0) begin
          push_word(WORD_MAP, $urandom_range(0, 255), $urandom_range(0, 1) == 1,
                    pick_gap());
        end
      end
      n = $urandom_range(2, 20);
      for (int i = 0; i < n; i++) begin
        push_word(WORD_MAP, $urandom_range(0, 255), $urandom_range(0, 1) == 1,
                  pick_gap());
      end
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (accepted_words < planned_words) @(posedge clk);
    while (expected_levels.size() > 0 || busy !== 1'b0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("Ran %0d count words and %0d map words through %0d table builds,",
             count_words, map_words, tables_built);
    $display("with random gaps between words; %0d levels checked, %0d mismatches.",
             levels_checked, mismatches);
    if (mismatches == 0 && expected_levels.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
